// ===== rtl/core/dumjs_pkg.sv =====
// shared types, constants and helpers for the joint move select block
package dumjs_pkg;

  localparam int CHOICE_COUNT_DEF = 32;
  localparam int MAX_ENTRIES_DEF  = 1024;

  localparam int CHOICE_W = 5;
  localparam int COUNT_W  = 32;
  localparam int PAIR_W   = 2 * CHOICE_W;
  localparam int SUM_W    = 42;
  localparam int SCORE_W  = 31;
  localparam int SEL_W    = 10;
  localparam int GAIN_W   = 16;
  localparam int LOG2_W   = 22;
  localparam int EXPL_W   = 35;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [15:0]        LN2_Q16   = 16'd45426;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd2048;

  // shared divide / square root unit
  localparam int AR_A_W = 58;
  localparam int AR_B_W = 42;
  localparam int AR_R_W = 31;

  localparam int  APB_ADDR_W = 3;
  localparam logic REG_GAIN  = 1'b0;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic {
    AR_DIV  = 1'b0,
    AR_SQRT = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic              start;
    arith_op_t         op;
    logic [AR_A_W-1:0] a;
    logic [AR_B_W-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [AR_R_W-1:0] res;
  } arith_rsp_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// ===== rtl/core/dumjs_arith.sv =====
// shared iterative unit: restoring divide and digit-by-digit square root
module dumjs_arith import dumjs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  logic              busy;
  logic              done;
  arith_op_t         op_q;
  logic [AR_A_W-1:0] acc;
  logic [AR_B_W-1:0] b_q;
  logic [42:0]       rem;
  logic [AR_R_W-1:0] res;
  logic [4:0]        cnt;
  logic [42:0]       x;
  logic [42:0]       y;
  logic [42:0]       diff;
  logic              ge;

  // one subtractor serves both operations
  always_comb begin
    if (op_q == AR_DIV) begin
      x = {rem[41:0], acc[AR_A_W-1]};
      y = {1'b0, b_q};
    end else begin
      x = {rem[40:0], acc[AR_A_W-1:AR_A_W-2]};
      y = {10'b0, res, 2'b01};
    end
    ge   = (x >= y);
    diff = x - y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_q <= req.op;
      b_q  <= req.b;
      res  <= '0;
      if (req.op == AR_DIV) begin
        acc <= {req.a[30:0], 27'b0};
        rem <= {16'b0, req.a[AR_A_W-1:31]};
        cnt <= 5'd30;
      end else begin
        acc <= req.a;
        rem <= '0;
        cnt <= 5'd28;
      end
    end else if (busy) begin
      rem <= ge ? diff : x;
      res <= {res[AR_R_W-2:0], ge};
      acc <= (op_q == AR_DIV) ? {acc[AR_A_W-2:0], 1'b0} : {acc[AR_A_W-3:0], 2'b00};
      cnt <= cnt - 5'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

// ===== rtl/core/decoupled_ucb_joint_move_select.sv =====
// top level: entry load, per-choice ucb1 scoring sequencer and pair search
// load: an item is accepted in idle (read of the choice sums), then the load state writes them back
// select (item with tlast): ln and the exploration term first, then per used choice of each
//   player one or two divides and one root on the shared divide/sqrt unit, then a read and
//   compare per stored entry searched for the best pair
// s_tready is low from acceptance until write back, with tlast until the result is in the output register
// reset is synchronous; node sums are tracked by valid flops, so there is no clearing pass
module decoupled_ucb_joint_move_select import dumjs_pkg::*; #(
  parameter int CHOICE_COUNT = CHOICE_COUNT_DEF,
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // apb configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // entry items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // first_player_choice, second_player_choice, entry_visits, entry_wins
  input  logic [79:0]           s_tdata,
  input  logic                  s_tlast,
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // selected_entry, best_first_choice, best_second_choice
  output logic [23:0]           m_tdata,
  // select_status
  output logic [1:0]            m_tuser
);

  localparam int CH_W  = (CHOICE_COUNT > 1) ? $clog2(CHOICE_COUNT) : 1;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_LOAD     = 18'h00002,
    S_LN_INIT  = 18'h00004,
    S_LN_NORM  = 18'h00008,
    S_LN_MUL   = 18'h00010,
    S_LN_STEP  = 18'h00020,
    S_LN_SCALE = 18'h00040,
    S_EXP_SQRT = 18'h00080,
    S_EXP_MUL  = 18'h00100,
    S_CH_RD    = 18'h00200,
    S_CH_CHK   = 18'h00400,
    S_CH_DIV1  = 18'h00800,
    S_CH_SQRT  = 18'h01000,
    S_CH_DIV2  = 18'h02000,
    S_CH_CMP   = 18'h04000,
    S_SR_RD    = 18'h08000,
    S_SR_CMP   = 18'h10000,
    S_FINISH   = 18'h20000
  } state_t;

  state_t state;

  // configuration register
  logic [GAIN_W-1:0] gain;
  logic              cfg_wr;
  logic              cfg_is_gain;

  assign pready      = 1'b1;
  assign cfg_is_gain = (paddr[APB_ADDR_W-1:2] == REG_GAIN);
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign prdata      = cfg_is_gain ? {16'b0, gain} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_wr && cfg_is_gain) begin
      gain <= pwdata[GAIN_W-1:0];
    end
  end

  // input fields
  logic [CHOICE_W-1:0] first_player_choice;
  logic [CHOICE_W-1:0] second_player_choice;
  logic [COUNT_W-1:0]  entry_visits;
  logic [COUNT_W-1:0]  entry_wins;
  logic                last_entry;

  assign first_player_choice  = s_tdata[4:0];
  assign second_player_choice = s_tdata[9:5];
  assign entry_visits         = s_tdata[41:10];
  assign entry_wins           = s_tdata[73:42];
  assign last_entry           = s_tlast;

  assign s_tready = (state == S_IDLE);

  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  // latched item
  logic [CHOICE_W-1:0] c0_q;
  logic [CHOICE_W-1:0] c1_q;
  logic [COUNT_W-1:0]  vis_q;
  logic [COUNT_W-1:0]  win_q;
  logic                last_q;

  // per player choice sums, one memory each, valid flops mark written choices
  logic [SUM_W-1:0] win0_mem   [CHOICE_COUNT];
  logic [SUM_W-1:0] vis0_mem   [CHOICE_COUNT];
  logic [IDX_W-1:0] first0_mem [CHOICE_COUNT];
  logic [SUM_W-1:0] win1_mem   [CHOICE_COUNT];
  logic [SUM_W-1:0] vis1_mem   [CHOICE_COUNT];
  logic [IDX_W-1:0] first1_mem [CHOICE_COUNT];
  logic [CHOICE_COUNT-1:0] vld0;
  logic [CHOICE_COUNT-1:0] vld1;

  logic [SUM_W-1:0] rd_win0, rd_vis0, rd_win1, rd_vis1;
  logic [IDX_W-1:0] rd_first0, rd_first1;

  // stored pairs in load order
  logic [PAIR_W-1:0] ent_mem [MAX_ENTRIES];
  logic [PAIR_W-1:0] ent_rd;
  logic [IDX_W-1:0]  ent_idx;

  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] grand;
  logic             empty_q;

  // scan position over choices
  logic            sc_player;
  logic [CH_W-1:0] sc_idx;
  logic [CH_W-1:0] a0, a1;

  assign a0 = (state == S_IDLE) ? CH_W'(first_player_choice)  : sc_idx;
  assign a1 = (state == S_IDLE) ? CH_W'(second_player_choice) : sc_idx;

  always_ff @(posedge clk) begin
    rd_win0   <= win0_mem[a0];
    rd_vis0   <= vis0_mem[a0];
    rd_first0 <= first0_mem[a0];
    rd_win1   <= win1_mem[a1];
    rd_vis1   <= vis1_mem[a1];
    rd_first1 <= first1_mem[a1];
    ent_rd    <= ent_mem[ent_idx];
  end

  // load update
  logic [CH_W-1:0]  ca0, ca1;
  logic             store;
  logic [COUNT_W-1:0] lose1;
  logic [SUM_W-1:0] old_w0, old_v0, old_w1, old_v1;
  logic [SUM_W-1:0] new_w0, new_v0, new_w1, new_v1;
  logic [IDX_W-1:0] new_f0, new_f1;

  always_comb begin
    ca0    = CH_W'(c0_q);
    ca1    = CH_W'(c1_q);
    store  = (32'(c0_q) < CHOICE_COUNT) && (32'(c1_q) < CHOICE_COUNT) &&
             (count < CNT_W'(MAX_ENTRIES));
    lose1  = (vis_q > win_q) ? vis_q - win_q : '0;
    old_w0 = vld0[ca0] ? rd_win0 : '0;
    old_v0 = vld0[ca0] ? rd_vis0 : '0;
    old_w1 = vld1[ca1] ? rd_win1 : '0;
    old_v1 = vld1[ca1] ? rd_vis1 : '0;
    new_w0 = sat_add(old_w0, SUM_W'(win_q));
    new_v0 = sat_add(old_v0, SUM_W'(vis_q));
    new_w1 = sat_add(old_w1, SUM_W'(lose1));
    new_v1 = sat_add(old_v1, SUM_W'(vis_q));
    new_f0 = vld0[ca0] ? rd_first0 : IDX_W'(count);
    new_f1 = vld1[ca1] ? rd_first1 : IDX_W'(count);
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && store) begin
      win0_mem[ca0]   <= new_w0;
      vis0_mem[ca0]   <= new_v0;
      first0_mem[ca0] <= new_f0;
      win1_mem[ca1]   <= new_w1;
      vis1_mem[ca1]   <= new_v1;
      first1_mem[ca1] <= new_f1;
      ent_mem[IDX_W'(count)] <= {c1_q, c0_q};
    end
  end

  // selected choice record of the scan
  logic             sel_vld;
  logic [SUM_W-1:0] sel_v, sel_w;
  logic [IDX_W-1:0] sel_f;
  logic             ratio_sat;

  always_comb begin
    sel_vld   = sc_player ? vld1[sc_idx] : vld0[sc_idx];
    sel_v     = sc_player ? rd_vis1 : rd_vis0;
    sel_w     = sc_player ? rd_win1 : rd_win0;
    sel_f     = sc_player ? rd_first1 : rd_first0;
    ratio_sat = ({15'b0, sel_w} >= {sel_v, 15'b0});
  end

  // shared arithmetic unit
  arith_req_t        ar_req;
  arith_rsp_t        ar_rsp;
  logic              ar_go;
  logic              ar_start;
  arith_op_t         ar_op;
  logic [AR_A_W-1:0] ar_a;
  logic [AR_B_W-1:0] ar_b;

  assign ar_req = '{start: ar_start, op: ar_op, a: ar_a, b: ar_b};

  // start pulse for the shared unit, registered from the request state's decision, so it comes in the cycle after
  always_comb begin
    case (state)
      S_LN_INIT:            ar_go = (grand <= SUM_W'(1));
      S_LN_SCALE:           ar_go = 1'b1;
      S_CH_CHK:             ar_go = sel_vld && (sel_v != '0);
      S_CH_DIV1, S_CH_SQRT: ar_go = ar_rsp.done;
      default:              ar_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ar_start <= 1'b0;
    end else begin
      ar_start <= ar_go;
    end
  end

  dumjs_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (ar_req),
    .rsp (ar_rsp)
  );

  // ln and exploration term
  logic [SUM_W-1:0]  norm;
  logic [5:0]        lk;
  logic [30:0]       mant;
  logic [61:0]       prod;
  logic [15:0]       frac;
  logic [3:0]        lstep;
  logic [EXPL_W-1:0] explore;
  logic [31:0]       mq;
  logic [37:0]       ln_full;
  logic [46:0]       exp_full;

  assign mq       = prod[61:30];
  assign ln_full  = 38'({lk, frac}) * 38'(LN2_Q16);
  assign exp_full = 47'(gain) * 47'(ar_rsp.res);

  // scoring
  logic [SCORE_W-1:0] ratio;
  logic [SCORE_W-1:0] q_q;
  logic [31:0]        sum;
  logic [SCORE_W-1:0] score;
  logic [SCORE_W-1:0] best_score [2];
  logic [IDX_W-1:0]   best_first [2];
  logic [CHOICE_W-1:0] best_ch   [2];
  logic [1:0]         best_set;
  logic               better;
  logic               zero_seen;
  logic               last_choice;

  always_comb begin
    sum    = {1'b0, ratio} + {1'b0, q_q};
    score  = sum[31] ? SCORE_MAX : sum[SCORE_W-1:0];
    better = !best_set[sc_player] || (score > best_score[sc_player]) ||
             ((score == best_score[sc_player]) && (sel_f < best_first[sc_player]));
    last_choice = (sc_idx == CH_W'(CHOICE_COUNT - 1));
  end

  // output register
  logic [SEL_W-1:0]    out_sel;
  logic [CHOICE_W-1:0] out_b0, out_b1;
  status_t             out_st;
  logic [IDX_W-1:0]    found_idx;
  logic                found;
  logic                out_load;

  assign m_tdata  = {4'b0, out_b1, out_b0, out_sel};
  assign m_tuser  = out_st;
  assign out_load = (state == S_FINISH) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld0      <= '0;
      vld1      <= '0;
      count     <= '0;
      grand     <= '0;
      best_set  <= '0;
      zero_seen <= 1'b0;
      found     <= 1'b0;
      ar_op     <= AR_DIV;
      ar_a      <= '0;
      ar_b      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            c0_q   <= first_player_choice;
            c1_q   <= second_player_choice;
            vis_q  <= entry_visits;
            win_q  <= entry_wins;
            last_q <= last_entry;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (store) begin
            vld0[ca0] <= 1'b1;
            vld1[ca1] <= 1'b1;
            count     <= count + CNT_W'(1);
            grand     <= sat_add(grand, SUM_W'(vis_q));
          end
          empty_q <= !store && (count == '0);
          if (!last_q) begin
            state <= S_IDLE;
          end else if (!store && (count == '0)) begin
            state <= S_FINISH;
          end else begin
            state <= S_LN_INIT;
          end
        end
        S_LN_INIT: begin
          norm  <= grand;
          lk    <= 6'(SUM_W - 1);
          frac  <= '0;
          lstep <= '0;
          if (grand <= SUM_W'(1)) begin
            state <= S_EXP_SQRT;
            ar_op <= AR_SQRT;
            ar_a  <= '0;
            ar_b  <= '0;
          end else begin
            state <= S_LN_NORM;
          end
        end
        S_LN_NORM: begin
          // leading one search, one bit a cycle
          if (norm[SUM_W-1]) begin
            mant  <= norm[SUM_W-1:SUM_W-31];
            state <= S_LN_MUL;
          end else begin
            norm <= {norm[SUM_W-2:0], 1'b0};
            lk   <= lk - 6'd1;
          end
        end
        S_LN_MUL: begin
          prod  <= 62'(mant) * 62'(mant);
          state <= S_LN_STEP;
        end
        S_LN_STEP: begin
          if (mq[31]) begin
            mant <= mq[31:1];
            frac[4'd15 - lstep] <= 1'b1;
          end else begin
            mant <= mq[30:0];
          end
          if (lstep == 4'd15) begin
            state <= S_LN_SCALE;
          end else begin
            lstep <= lstep + 4'd1;
            state <= S_LN_MUL;
          end
        end
        S_LN_SCALE: begin
          state <= S_EXP_SQRT;
          ar_op <= AR_SQRT;
          ar_a  <= AR_A_W'({ln_full[37:16], 16'b0});
          ar_b  <= '0;
        end
        S_EXP_SQRT: begin
          if (ar_rsp.done) begin
            state <= S_EXP_MUL;
          end
        end
        S_EXP_MUL: begin
          explore   <= exp_full[46:12];
          sc_player <= 1'b0;
          sc_idx    <= '0;
          state     <= S_CH_RD;
        end
        S_CH_RD: begin
          state <= S_CH_CHK;
        end
        S_CH_CHK: begin
          if (sel_vld && sel_v == '0) begin
            zero_seen <= 1'b1;
          end
          if (sel_vld && sel_v != '0) begin
            if (ratio_sat) begin
              ratio <= SCORE_MAX;
              state <= S_CH_SQRT;
              ar_op <= AR_SQRT;
              ar_a  <= {sel_v, 16'b0};
              ar_b  <= '0;
            end else begin
              state <= S_CH_DIV1;
              ar_op <= AR_DIV;
              ar_a  <= {sel_w, 16'b0};
              ar_b  <= sel_v;
            end
          end else if (last_choice) begin
            if (sc_player) begin
              ent_idx <= '0;
              state   <= S_SR_RD;
            end else begin
              sc_player <= 1'b1;
              sc_idx    <= '0;
              state     <= S_CH_RD;
            end
          end else begin
            sc_idx <= sc_idx + CH_W'(1);
            state  <= S_CH_RD;
          end
        end
        S_CH_DIV1: begin
          if (ar_rsp.done) begin
            ratio <= ar_rsp.res;
            state <= S_CH_SQRT;
            ar_op <= AR_SQRT;
            ar_a  <= {sel_v, 16'b0};
            ar_b  <= '0;
          end
        end
        S_CH_SQRT: begin
          // explore is q19.16, the root is sqrt(visits) in q.8
          if (ar_rsp.done) begin
            state <= S_CH_DIV2;
            ar_op <= AR_DIV;
            ar_a  <= AR_A_W'({explore, 8'b0});
            ar_b  <= AR_B_W'(ar_rsp.res);
          end
        end
        S_CH_DIV2: begin
          if (ar_rsp.done) begin
            q_q   <= ar_rsp.res;
            state <= S_CH_CMP;
          end
        end
        S_CH_CMP: begin
          if (better) begin
            best_set[sc_player]   <= 1'b1;
            best_score[sc_player] <= score;
            best_first[sc_player] <= sel_f;
            best_ch[sc_player]    <= CHOICE_W'(sc_idx);
          end
          if (last_choice) begin
            if (sc_player) begin
              ent_idx <= '0;
              state   <= S_SR_RD;
            end else begin
              sc_player <= 1'b1;
              sc_idx    <= '0;
              state     <= S_CH_RD;
            end
          end else begin
            sc_idx <= sc_idx + CH_W'(1);
            state  <= S_CH_RD;
          end
        end
        S_SR_RD: begin
          state <= S_SR_CMP;
        end
        S_SR_CMP: begin
          // players with no scored choice report choice zero
          if (ent_rd[CHOICE_W-1:0] == (best_set[0] ? best_ch[0] : '0) &&
              ent_rd[PAIR_W-1:CHOICE_W] == (best_set[1] ? best_ch[1] : '0)) begin
            found     <= 1'b1;
            found_idx <= ent_idx;
            state     <= S_FINISH;
          end else if (CNT_W'(ent_idx) + CNT_W'(1) == count) begin
            state <= S_FINISH;
          end else begin
            ent_idx <= ent_idx + IDX_W'(1);
            state   <= S_SR_RD;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            if (empty_q) begin
              out_sel <= '0;
              out_b0  <= '0;
              out_b1  <= '0;
              out_st  <= ST_ABSENT;
            end else begin
              out_sel <= found ? SEL_W'(found_idx) : '0;
              out_b0  <= best_set[0] ? best_ch[0] : '0;
              out_b1  <= best_set[1] ? best_ch[1] : '0;
              out_st  <= zero_seen ? ST_ZERO : (found ? ST_OK : ST_ABSENT);
            end
            // clear node state for the next node
            vld0      <= '0;
            vld1      <= '0;
            count     <= '0;
            grand     <= '0;
            best_set  <= '0;
            zero_seen <= 1'b0;
            found     <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/dumjs_checker.sv =====
// port level checks for the joint move select block, bound to the top level
module dumjs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // status is never the unused code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3)
    else $error("bad select status");

  // the block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after accept");

  // reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind decoupled_ucb_joint_move_select dumjs_checker u_dumjs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
